// ----- hdl/gqe_pkg.sv -----
// ----------------------------------------------------------------------------
// gqe_pkg
// Types, constants and helpers shared by the glyph quad expander modules.
// ----------------------------------------------------------------------------
package gqe_pkg;

    // vertices emitted for one glyph (two triangles)
    localparam int VERTS_PER_GLYPH = 6;
    localparam int VTX_W           = $clog2(VERTS_PER_GLYPH);

    // exact-width position sum before saturation
    localparam int SUM_W = 18;

    typedef logic [VTX_W-1:0] t_vtx;

    localparam t_vtx LAST_VTX = t_vtx'(VERTS_PER_GLYPH - 1);

    // one glyph as it arrives
    typedef struct packed {
        logic               first_glyph;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic [14:0]        box_width;
        logic [14:0]        box_height;
        logic signed [15:0] pen_advance;
        logic [11:0]        tex_left;
        logic [11:0]        tex_top;
        logic [11:0]        tex_width;
        logic [11:0]        tex_height;
    } t_glyph_in;

    // one vertex as it leaves
    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [12:0]        tex_u;
        logic [12:0]        tex_v;
        logic               last_vertex;
    } t_vertex_out;

    // classified glyph: left, right, top and bottom edges in screen and texture space
    typedef struct packed {
        logic signed [15:0] xl;
        logic signed [15:0] xr;
        logic signed [15:0] yt;
        logic signed [15:0] yb;
        logic [12:0]        u0;
        logic [12:0]        u1;
        logic [12:0]        v0;
        logic [12:0]        v1;
    } t_quad;

    // queue status seen by the front, back and top
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // saturate an exact sum to signed 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [SUM_W-1:0] v);
        logic signed [15:0] r;
        if (v > SUM_W'(32767)) begin
            r = 16'sh7FFF;
        end else if (v < -SUM_W'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // corner order 0,1,2,0,3,2: right side for corners 1 and 2
    function automatic logic vtx_right(input t_vtx k);
        logic r;
        case (k)
            t_vtx'(1), t_vtx'(2), t_vtx'(5): r = 1'b1;
            default:                         r = 1'b0;
        endcase
        return r;
    endfunction

    // bottom side for corners 2 and 3
    function automatic logic vtx_bottom(input t_vtx k);
        logic r;
        case (k)
            t_vtx'(2), t_vtx'(4), t_vtx'(5): r = 1'b1;
            default:                         r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/gqe_front.sv -----
// ----------------------------------------------------------------------------
// gqe_front
// Accepts glyphs, tracks the pen offset and computes the quad edges.
// ----------------------------------------------------------------------------
module gqe_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  gqe_pkg::t_glyph_in i_glyph,
    input  gqe_pkg::t_q_status i_q_status,
    output logic               o_stall,
    output logic               o_push,
    output gqe_pkg::t_quad     o_quad
);

    logic signed [15:0] r_pen;
    logic signed [15:0] n_pen;
    logic signed [15:0] pen_eff;

    // stall only while the queue has no room
    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    // pen offset cleared at the start of a string
    assign pen_eff = i_glyph.first_glyph ? 16'sd0 : r_pen;

    // edge computation, exact sums then saturation
    always_comb begin
        o_quad.xl = gqe_pkg::sat16(gqe_pkg::SUM_W'(i_glyph.box_left)
                                   + gqe_pkg::SUM_W'(pen_eff));
        o_quad.xr = gqe_pkg::sat16(gqe_pkg::SUM_W'(i_glyph.box_left)
                                   + $signed({3'b000, i_glyph.box_width})
                                   + gqe_pkg::SUM_W'(pen_eff));
        o_quad.yt = i_glyph.box_top;
        o_quad.yb = gqe_pkg::sat16(gqe_pkg::SUM_W'(i_glyph.box_top)
                                   + $signed({3'b000, i_glyph.box_height}));
        o_quad.u0 = {1'b0, i_glyph.tex_left};
        o_quad.u1 = {1'b0, i_glyph.tex_left} + {1'b0, i_glyph.tex_width};
        o_quad.v0 = {1'b0, i_glyph.tex_top};
        o_quad.v1 = {1'b0, i_glyph.tex_top} + {1'b0, i_glyph.tex_height};
    end

    // pen grows by the advance after each glyph
    assign n_pen = gqe_pkg::sat16(gqe_pkg::SUM_W'(pen_eff)
                                  + gqe_pkg::SUM_W'(i_glyph.pen_advance));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen <= 16'sd0;
        end else if (o_push) begin
            r_pen <= n_pen;
        end
    end

endmodule

// ----- hdl/gqe_fifo.sv -----
// ----------------------------------------------------------------------------
// gqe_fifo
// Short queue of classified glyphs between front and back.
// ----------------------------------------------------------------------------
module gqe_fifo #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gqe_pkg::t_quad     i_quad,
    input  logic               i_pop,
    output gqe_pkg::t_quad     o_quad,
    output gqe_pkg::t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gqe_pkg::t_quad   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_quad         = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_quad;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/gqe_back.sv -----
// ----------------------------------------------------------------------------
// gqe_back
// Walks the six vertices of the queued quad and drives the result channel.
// ----------------------------------------------------------------------------
module gqe_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gqe_pkg::t_quad       i_quad,
    input  gqe_pkg::t_q_status   i_q_status,
    input  logic                 i_stall,
    output logic                 o_pop,
    output logic                 o_valid,
    output gqe_pkg::t_vertex_out o_vertex
);

    gqe_pkg::t_vtx r_vtx;
    logic          right;
    logic          bottom;
    logic          fire;

    assign o_valid = !i_q_status.empty;
    assign fire    = o_valid && !i_stall;
    assign o_pop   = fire && (r_vtx == gqe_pkg::LAST_VTX);
    assign right   = gqe_pkg::vtx_right(r_vtx);
    assign bottom  = gqe_pkg::vtx_bottom(r_vtx);

    // corner select
    always_comb begin
        o_vertex.pos_x       = right  ? i_quad.xr : i_quad.xl;
        o_vertex.pos_y       = bottom ? i_quad.yb : i_quad.yt;
        o_vertex.tex_u       = right  ? i_quad.u1 : i_quad.u0;
        o_vertex.tex_v       = bottom ? i_quad.v1 : i_quad.v0;
        o_vertex.last_vertex = (r_vtx == gqe_pkg::LAST_VTX);
    end

    // vertex counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtx <= '0;
        end else if (fire) begin
            r_vtx <= (r_vtx == gqe_pkg::LAST_VTX) ? '0 : r_vtx + 1'b1;
        end
    end

endmodule

// ----- hdl/glyph_quad_expander_unit.sv -----
// ----------------------------------------------------------------------------
// glyph_quad_expander_unit
// Expands each glyph into six vertices (two triangles) with a running pen.
// ----------------------------------------------------------------------------
// the first vertex is offered in the cycle after acceptance into an empty queue
// glyph throughput is set by the single vertex result port, one vertex at a time
// the queue of QUEUE_DEPTH glyphs lets the next glyph enter while one is drained
// reset clears pen offset, queue and vertex counter; no clearing pass
module glyph_quad_expander_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  gqe_pkg::t_glyph_in   i_glyph,
    output logic                 o_stall,
    output logic                 o_valid,
    output gqe_pkg::t_vertex_out o_vertex,
    input  logic                 i_stall
);

    gqe_pkg::t_q_status q_status;
    gqe_pkg::t_quad     push_quad;
    gqe_pkg::t_quad     head_quad;
    logic               push;
    logic               pop;

    // accept and classify
    gqe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_glyph    (i_glyph),
        .i_q_status (q_status),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_quad     (push_quad)
    );

    // decoupling queue
    gqe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_quad   (push_quad),
        .i_pop    (pop),
        .o_quad   (head_quad),
        .o_status (q_status)
    );

    // vertex emission
    gqe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_quad     (head_quad),
        .i_q_status (q_status),
        .i_stall    (i_stall),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_vertex   (o_vertex)
    );

    // queue can never be both full and empty
    a_q_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");

    // a glyph is never dropped in the middle of its six vertices
    a_no_mid_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_vertex.last_vertex) |=> o_valid)
        else $error("vertex stream broke mid glyph");

    // after a glyph is accepted, the result side offers a vertex next cycle
    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted glyph not presented");

    // the queue only pops on the last vertex of a glyph
    a_pop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (o_valid && !i_stall && o_vertex.last_vertex))
        else $error("queue popped before last vertex");

endmodule
